### rtl/pcce_pkg.sv
// Shared sizes and types for the pairwise Coulomb energy and force block.
package pcce_pkg;

    localparam int MAX_NUCLEI = 16;
    localparam int MAX_POINTS = 32;

    localparam int NI_W  = (MAX_NUCLEI > 1) ? $clog2(MAX_NUCLEI) : 1;
    localparam int NP_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NQ_CW = $clog2(MAX_NUCLEI + 1);
    localparam int NP_CW = $clog2(MAX_POINTS + 1);

    // Datapath width of the shared unit and its step counts
    localparam int ALU_W      = 100;
    localparam int MUL_STEPS  = 33;
    localparam int DIV_NW     = 96;
    localparam int SQ_W       = 66;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int CNT_W      = 7;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_stat;

endpackage

### rtl/point_charge_coulomb_energy_force.sv
// Top level: charge stores, force stores and the pair-walk sequencer.
//
// Input channel (i_in_valid / o_in_ready) carries one action per transfer:
// load nucleus, load classical charge, compute, read nucleus force, read
// charge force. Loads give no result. A read gives one result from the
// force store, registered through S_RD_WAIT and S_PUT. A compute walks
// every (nucleus, charge) pair through one shared iterative unit (each
// multiply, divide or square root holds the sequencer until the unit is
// done); a coincident pair skips the square root and force steps, and one
// energy result is given after the last pair.
// The input channel is ready only while the sequencer is idle; a finished
// result sits in the output register (o_out_valid / i_out_ready), so loads
// are taken while it waits, and a later result holds until it is taken.
// Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) writes qm_count (index 0)
// and mm_count (index 1).
// Reset (i_rst_n low, synchronous) clears counts, energy, status and the force
// store valid flags; position and charge stores are undefined until loaded.
module point_charge_coulomb_energy_force
    import pcce_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [5:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_action,
    input  logic [4:0]         i_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [23:0] i_charge,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_result_kind,
    output logic signed [47:0] o_energy,
    output logic signed [47:0] o_force_x,
    output logic signed [47:0] o_force_y,
    output logic signed [47:0] o_force_z,
    output logic [1:0]         o_status
);

    localparam logic [2:0] ACT_LOAD_NUC = 3'd0;
    localparam logic [2:0] ACT_LOAD_PT  = 3'd1;
    localparam logic [2:0] ACT_COMPUTE  = 3'd2;
    localparam logic [2:0] ACT_READ_NUC = 3'd3;
    localparam logic [2:0] ACT_READ_PT  = 3'd4;

    localparam logic [1:0] KIND_ENERGY = 2'd0;
    localparam logic [1:0] KIND_NUC    = 2'd1;
    localparam logic [1:0] KIND_PT     = 2'd2;

    localparam logic [1:0] CFG_QM = 2'd0;
    localparam logic [1:0] CFG_MM = 2'd1;

    localparam int POS_W = 32;
    localparam int CHG_W = 24;
    localparam int F_W   = 48;
    localparam int D_W   = 33;
    localparam int QQ_W  = 47;
    localparam int R_W   = 33;
    localparam int R3_W  = 99;
    localparam int NUM_W = 80;
    localparam int PW_W  = 3 * POS_W + CHG_W;
    localparam int FW_W  = 3 * F_W;

    localparam logic [F_W-1:0] LIM_POS = {1'b0, {(F_W-1){1'b1}}};
    localparam logic [F_W-1:0] LIM_NEG = {1'b1, {(F_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_RD_WAIT, S_PUT, S_C_WAIT, S_C_LAT, S_SQ, S_SQRT, S_QQ,
        S_EDIV, S_R2, S_R3, S_FMUL, S_FDIV, S_ACC, S_WR, S_NEXT
    } t_state;

    typedef struct packed {
        logic                  ovf;
        logic signed [F_W-1:0] val;
    } t_sat;

    function automatic t_sat sat48(input logic signed [F_W+1:0] s);
        t_sat res;
        if (s > $signed({2'b00, LIM_POS})) begin
            res.ovf = 1'b1;
            res.val = LIM_POS;
        end else if (s < $signed({2'b11, LIM_NEG})) begin
            res.ovf = 1'b1;
            res.val = LIM_NEG;
        end else begin
            res.ovf = 1'b0;
            res.val = s[F_W-1:0];
        end
        return res;
    endfunction

    t_state                 r_state;
    logic [4:0]             r_qm;
    logic [5:0]             r_mm;
    logic [NQ_CW-1:0]       r_nq;
    logic [NP_CW-1:0]       r_np;
    logic [NI_W-1:0]        r_i;
    logic [NP_W-1:0]        r_j;
    logic [1:0]             r_c;
    logic                   r_go;
    logic [D_W-1:0]         r_dmag [3];
    logic                   r_dneg [3];
    logic signed [CHG_W-1:0] r_qi;
    logic signed [CHG_W-1:0] r_qj;
    logic [SQ_W-1:0]        r_d2;
    logic [R_W-1:0]         r_r;
    logic [QQ_W-1:0]        r_qq;
    logic [R3_W-1:0]        r_r3;
    logic [NUM_W-1:0]       r_num;
    logic signed [F_W-1:0]  r_f [3];
    logic signed [F_W-1:0]  r_nfw [3];
    logic signed [F_W-1:0]  r_pfw [3];
    logic signed [F_W-1:0]  r_energy;
    logic [1:0]             r_status;
    logic [MAX_NUCLEI-1:0]  r_nf_vld;
    logic [MAX_POINTS-1:0]  r_pf_vld;
    logic [4:0]             r_ridx;
    logic [1:0]             r_res_kind;
    logic signed [F_W-1:0]  r_res_f [3];
    logic                   r_out_valid;
    logic [1:0]             r_o_kind;
    logic signed [F_W-1:0]  r_o_energy;
    logic signed [F_W-1:0]  r_o_f [3];
    logic [1:0]             r_o_status;

    logic                   in_xfer;
    logic                   put_ok;
    logic                   out_load;
    logic [PW_W-1:0]        nuc_rd;
    logic [PW_W-1:0]        pt_rd;
    logic [FW_W-1:0]        nf_rd;
    logic [FW_W-1:0]        pf_rd;
    logic [NI_W-1:0]        nf_raddr;
    logic [NP_W-1:0]        pf_raddr;
    logic                   nuc_we;
    logic                   pt_we;
    logic                   frc_we;

    t_alu_cmd               alu_cmd;
    t_alu_stat              alu_stat;
    logic [ALU_W-1:0]       alu_opa;
    logic [ALU_W-1:0]       alu_opb;
    logic [ALU_W-1:0]       alu_res;
    logic                   op_state;

    logic [D_W-1:0]         dmag_c;
    logic [CHG_W-1:0]       qi_mag;
    logic [CHG_W-1:0]       qj_mag;
    logic                   qq_neg;
    logic [SQ_W-1:0]        d2_sum;
    logic signed [F_W+1:0]  e_add;
    t_sat                   e_sat;
    logic                   f_neg;
    logic [F_W-1:0]         f_lim;
    logic                   f_ovf;
    logic [F_W-1:0]         f_mag;
    logic signed [F_W-1:0]  f_val;
    logic signed [F_W-1:0]  nf_cur;
    logic signed [F_W-1:0]  pf_cur;
    t_sat                   n_sat;
    t_sat                   p_sat;
    logic [NQ_CW-1:0]       n_nq;
    logic [NP_CW-1:0]       n_np;
    logic                   last_i;
    logic                   last_j;
    logic                   rd_nuc_ok;
    logic                   rd_pt_ok;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign put_ok     = !r_out_valid || i_out_ready;
    assign out_load   = (r_state == S_PUT) && put_ok;

    assign nuc_we = in_xfer && (i_action == ACT_LOAD_NUC) && (int'(i_index) < MAX_NUCLEI);
    assign pt_we  = in_xfer && (i_action == ACT_LOAD_PT) && (int'(i_index) < MAX_POINTS);
    assign frc_we = (r_state == S_WR);

    assign nf_raddr = (r_state == S_IDLE) ? NI_W'(i_index) : r_i;
    assign pf_raddr = (r_state == S_IDLE) ? NP_W'(i_index) : r_j;

    pcce_ram #(.W(PW_W), .D(MAX_NUCLEI)) u_nuc_pos (
        .i_clk   (i_clk),
        .i_we    (nuc_we),
        .i_waddr (NI_W'(i_index)),
        .i_wdata ({i_charge, i_pos_z, i_pos_y, i_pos_x}),
        .i_raddr (r_i),
        .o_rdata (nuc_rd)
    );

    pcce_ram #(.W(PW_W), .D(MAX_POINTS)) u_pt_pos (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (NP_W'(i_index)),
        .i_wdata ({i_charge, i_pos_z, i_pos_y, i_pos_x}),
        .i_raddr (r_j),
        .o_rdata (pt_rd)
    );

    pcce_ram #(.W(FW_W), .D(MAX_NUCLEI)) u_nuc_frc (
        .i_clk   (i_clk),
        .i_we    (frc_we),
        .i_waddr (r_i),
        .i_wdata ({r_nfw[2], r_nfw[1], r_nfw[0]}),
        .i_raddr (nf_raddr),
        .o_rdata (nf_rd)
    );

    pcce_ram #(.W(FW_W), .D(MAX_POINTS)) u_pt_frc (
        .i_clk   (i_clk),
        .i_we    (frc_we),
        .i_waddr (r_j),
        .i_wdata ({r_pfw[2], r_pfw[1], r_pfw[0]}),
        .i_raddr (pf_raddr),
        .o_rdata (pf_rd)
    );

    pcce_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (alu_cmd),
        .i_opa   (alu_opa),
        .i_opb   (alu_opb),
        .o_stat  (alu_stat),
        .o_res   (alu_res)
    );

    // Operand selection for the shared unit
    always_comb begin
        dmag_c   = r_dmag[r_c];
        qi_mag   = r_qi[CHG_W-1] ? CHG_W'(-r_qi) : CHG_W'(r_qi);
        qj_mag   = r_qj[CHG_W-1] ? CHG_W'(-r_qj) : CHG_W'(r_qj);
        op_state = 1'b1;
        alu_cmd.op = ALU_MUL;
        alu_opa  = '0;
        alu_opb  = '0;
        unique case (r_state)
            S_SQ: begin
                alu_opa = ALU_W'(dmag_c);
                alu_opb = ALU_W'(dmag_c);
            end
            S_SQRT: begin
                alu_cmd.op = ALU_SQRT;
                alu_opb    = ALU_W'(r_d2);
            end
            S_QQ: begin
                alu_opa = ALU_W'(qi_mag);
                alu_opb = ALU_W'(qj_mag);
            end
            S_EDIV: begin
                alu_cmd.op = ALU_DIV;
                alu_opa    = ALU_W'(r_r);
                alu_opb    = ALU_W'(r_qq);
            end
            S_R2: begin
                alu_opa = ALU_W'(r_r);
                alu_opb = ALU_W'(r_r);
            end
            S_R3: begin
                alu_opa = ALU_W'(r_r3);
                alu_opb = ALU_W'(r_r);
            end
            S_FMUL: begin
                alu_opa = ALU_W'(r_qq);
                alu_opb = ALU_W'(dmag_c);
            end
            S_FDIV: begin
                alu_cmd.op = ALU_DIV;
                alu_opa    = ALU_W'(r_r3);
                alu_opb    = ALU_W'({r_num, 16'h0000});
            end
            default: begin
                op_state = 1'b0;
            end
        endcase
        alu_cmd.start = op_state && !r_go;
    end

    // Pair arithmetic around the shared unit
    always_comb begin
        qq_neg = r_qi[CHG_W-1] ^ r_qj[CHG_W-1];
        d2_sum = r_d2 + alu_res[SQ_W-1:0];

        e_add = qq_neg ? -$signed({3'b000, alu_res[QQ_W-1:0]})
                       :  $signed({3'b000, alu_res[QQ_W-1:0]});
        e_sat = sat48($signed({{2{r_energy[F_W-1]}}, r_energy}) + e_add);

        f_neg = (qq_neg == r_dneg[r_c]);
        f_lim = f_neg ? LIM_NEG : LIM_POS;
        f_ovf = (|alu_res[DIV_NW-1:F_W]) || (alu_res[F_W-1:0] > f_lim);
        f_mag = f_ovf ? f_lim : alu_res[F_W-1:0];
        f_val = f_neg ? -$signed(f_mag) : $signed(f_mag);

        nf_cur = r_nf_vld[r_i] ? $signed(nf_rd[r_c*F_W +: F_W]) : '0;
        pf_cur = r_pf_vld[r_j] ? $signed(pf_rd[r_c*F_W +: F_W]) : '0;
        n_sat  = sat48($signed({{2{nf_cur[F_W-1]}}, nf_cur})
                     + $signed({{2{r_f[r_c][F_W-1]}}, r_f[r_c]}));
        p_sat  = sat48($signed({{2{pf_cur[F_W-1]}}, pf_cur})
                     - $signed({{2{r_f[r_c][F_W-1]}}, r_f[r_c]}));

        n_nq = (int'(r_qm) > MAX_NUCLEI) ? NQ_CW'(MAX_NUCLEI) : NQ_CW'(r_qm);
        n_np = (int'(r_mm) > MAX_POINTS) ? NP_CW'(MAX_POINTS) : NP_CW'(r_mm);
        last_i = (NQ_CW'(r_i) + NQ_CW'(1)) == r_nq;
        last_j = (NP_CW'(r_j) + NP_CW'(1)) == r_np;

        rd_nuc_ok = (int'(r_ridx) < MAX_NUCLEI) && r_nf_vld[NI_W'(r_ridx)];
        rd_pt_ok  = (int'(r_ridx) < MAX_POINTS) && r_pf_vld[NP_W'(r_ridx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qm        <= '0;
            r_mm        <= '0;
            r_go        <= 1'b0;
            r_c         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_energy    <= '0;
            r_status    <= '0;
            r_nf_vld    <= '0;
            r_pf_vld    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_QM) begin
                    r_qm <= i_cfg_data[4:0];
                end else if (i_cfg_idx == CFG_MM) begin
                    r_mm <= i_cfg_data;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (alu_cmd.start) begin
                r_go <= 1'b1;
            end else if (alu_stat.done) begin
                r_go <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_ridx <= i_index;
                        priority if (i_action == ACT_COMPUTE) begin
                            r_energy   <= '0;
                            r_status   <= '0;
                            r_nf_vld   <= '0;
                            r_pf_vld   <= '0;
                            r_nq       <= n_nq;
                            r_np       <= n_np;
                            r_i        <= '0;
                            r_j        <= '0;
                            r_c        <= '0;
                            r_res_kind <= KIND_ENERGY;
                            r_res_f    <= '{default: '0};
                            r_state    <= (n_nq == '0 || n_np == '0) ? S_PUT : S_C_WAIT;
                        end else if (i_action == ACT_READ_NUC) begin
                            r_res_kind <= KIND_NUC;
                            r_state    <= S_RD_WAIT;
                        end else if (i_action == ACT_READ_PT) begin
                            r_res_kind <= KIND_PT;
                            r_state    <= S_RD_WAIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RD_WAIT: begin
                    for (int c = 0; c < 3; c++) begin
                        if (r_res_kind == KIND_NUC) begin
                            r_res_f[c] <= rd_nuc_ok ? $signed(nf_rd[c*F_W +: F_W]) : '0;
                        end else begin
                            r_res_f[c] <= rd_pt_ok ? $signed(pf_rd[c*F_W +: F_W]) : '0;
                        end
                    end
                    r_state <= S_PUT;
                end
                S_PUT: begin
                    if (put_ok) begin
                        r_o_kind    <= r_res_kind;
                        r_o_energy  <= (r_res_kind == KIND_ENERGY) ? r_energy : '0;
                        r_o_f       <= r_res_f;
                        r_o_status  <= r_status;
                        r_state     <= S_IDLE;
                    end
                end
                S_C_WAIT: begin
                    // let the position stores present the new pair
                    r_state <= S_C_LAT;
                end
                S_C_LAT: begin
                    for (int c = 0; c < 3; c++) begin
                        logic signed [D_W-1:0] d;
                        d = $signed({nuc_rd[c*POS_W + POS_W-1], nuc_rd[c*POS_W +: POS_W]})
                          - $signed({pt_rd[c*POS_W + POS_W-1], pt_rd[c*POS_W +: POS_W]});
                        r_dneg[c] <= d[D_W-1];
                        r_dmag[c] <= d[D_W-1] ? D_W'(-d) : D_W'(d);
                    end
                    r_qi    <= $signed(nuc_rd[PW_W-1 -: CHG_W]);
                    r_qj    <= $signed(pt_rd[PW_W-1 -: CHG_W]);
                    r_d2    <= '0;
                    r_c     <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (alu_stat.done) begin
                        r_d2 <= d2_sum;
                        if (r_c == 2'd2) begin
                            r_c <= '0;
                            if (d2_sum == '0) begin
                                // coincident pair adds nothing
                                r_status[0] <= 1'b1;
                                r_state     <= S_NEXT;
                            end else begin
                                r_state <= S_SQRT;
                            end
                        end else begin
                            r_c <= r_c + 2'd1;
                        end
                    end
                end
                S_SQRT: begin
                    if (alu_stat.done) begin
                        r_r     <= alu_res[R_W-1:0];
                        r_state <= S_QQ;
                    end
                end
                S_QQ: begin
                    if (alu_stat.done) begin
                        r_qq    <= alu_res[QQ_W-1:0];
                        r_state <= S_EDIV;
                    end
                end
                S_EDIV: begin
                    if (alu_stat.done) begin
                        r_energy <= e_sat.val;
                        if (e_sat.ovf) begin
                            r_status[1] <= 1'b1;
                        end
                        r_state <= S_R2;
                    end
                end
                S_R2: begin
                    if (alu_stat.done) begin
                        r_r3    <= alu_res[R3_W-1:0];
                        r_state <= S_R3;
                    end
                end
                S_R3: begin
                    if (alu_stat.done) begin
                        r_r3    <= alu_res[R3_W-1:0];
                        r_c     <= '0;
                        r_state <= S_FMUL;
                    end
                end
                S_FMUL: begin
                    if (alu_stat.done) begin
                        r_num   <= alu_res[NUM_W-1:0];
                        r_state <= S_FDIV;
                    end
                end
                S_FDIV: begin
                    if (alu_stat.done) begin
                        r_f[r_c] <= f_val;
                        if (f_ovf) begin
                            r_status[1] <= 1'b1;
                        end
                        if (r_c == 2'd2) begin
                            r_c     <= '0;
                            r_state <= S_ACC;
                        end else begin
                            r_c     <= r_c + 2'd1;
                            r_state <= S_FMUL;
                        end
                    end
                end
                S_ACC: begin
                    r_nfw[r_c] <= n_sat.val;
                    r_pfw[r_c] <= p_sat.val;
                    if (n_sat.ovf || p_sat.ovf) begin
                        r_status[1] <= 1'b1;
                    end
                    if (r_c == 2'd2) begin
                        r_c     <= '0;
                        r_state <= S_WR;
                    end else begin
                        r_c <= r_c + 2'd1;
                    end
                end
                S_WR: begin
                    r_nf_vld[r_i] <= 1'b1;
                    r_pf_vld[r_j] <= 1'b1;
                    r_state       <= S_NEXT;
                end
                S_NEXT: begin
                    if (last_j) begin
                        r_j <= '0;
                        if (last_i) begin
                            r_state <= S_PUT;
                        end else begin
                            r_i     <= r_i + NI_W'(1);
                            r_state <= S_C_WAIT;
                        end
                    end else begin
                        r_j     <= r_j + NP_W'(1);
                        r_state <= S_C_WAIT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_o_kind;
    assign o_energy      = r_o_energy;
    assign o_force_x     = r_o_f[0];
    assign o_force_y     = r_o_f[1];
    assign o_force_z     = r_o_f[2];
    assign o_status      = r_o_status;

endmodule

### rtl/pcce_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module pcce_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                          i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                          o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pcce_alu.sv
// Shared iterative unit: shift-add multiply, restoring divide, bitwise square root.
module pcce_alu
    import pcce_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_alu_cmd         i_cmd,
    input  logic [ALU_W-1:0] i_opa,
    input  logic [ALU_W-1:0] i_opb,
    output t_alu_stat        o_stat,
    output logic [ALU_W-1:0] o_res
);

    logic             r_busy;
    logic             r_done;
    t_alu_op          r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [ALU_W-1:0] r_acc;
    logic [ALU_W-1:0] r_opa;
    logic [ALU_W-1:0] r_opb;

    logic [ALU_W-1:0] add_x;
    logic [ALU_W-1:0] add_y;
    logic             sub;
    logic [ALU_W:0]   sum;
    logic             ge;
    logic [CNT_W-1:0] last_cnt;

    always_comb begin
        add_x    = r_acc;
        add_y    = r_opa;
        sub      = 1'b0;
        last_cnt = CNT_W'(MUL_STEPS - 1);
        unique case (r_op)
            ALU_MUL: begin
                add_x    = r_acc;
                add_y    = r_opa;
                sub      = 1'b0;
                last_cnt = CNT_W'(MUL_STEPS - 1);
            end
            ALU_DIV: begin
                // bring down next numerator bit
                add_x    = {r_acc[ALU_W-2:0], r_opb[DIV_NW-1]};
                add_y    = r_opa;
                sub      = 1'b1;
                last_cnt = CNT_W'(DIV_NW - 1);
            end
            ALU_SQRT: begin
                add_x    = {r_acc[ALU_W-3:0], r_opb[SQ_W-1 -: 2]};
                add_y    = {r_opa[ALU_W-3:0], 2'b01};
                sub      = 1'b1;
                last_cnt = CNT_W'(SQRT_STEPS - 1);
            end
            default: begin
                add_x    = r_acc;
                add_y    = '0;
                sub      = 1'b0;
                last_cnt = '0;
            end
        endcase
        sum = {1'b0, add_x} + {1'b0, (sub ? ~add_y : add_y)} + (ALU_W+1)'(sub);
        ge  = sum[ALU_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ALU_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_opa  <= (i_cmd.op == ALU_SQRT) ? '0 : i_opa;
                r_opb  <= i_opb;
            end else if (r_busy) begin
                unique case (r_op)
                    ALU_MUL: begin
                        if (r_opb[0]) begin
                            r_acc <= sum[ALU_W-1:0];
                        end
                        r_opa <= {r_opa[ALU_W-2:0], 1'b0};
                        r_opb <= {1'b0, r_opb[ALU_W-1:1]};
                    end
                    ALU_DIV: begin
                        r_acc <= ge ? sum[ALU_W-1:0] : add_x;
                        r_opb <= {r_opb[ALU_W-2:0], ge};
                    end
                    ALU_SQRT: begin
                        r_acc <= ge ? sum[ALU_W-1:0] : add_x;
                        r_opa <= {r_opa[ALU_W-2:0], ge};
                        r_opb <= {r_opb[ALU_W-3:0], 2'b00};
                    end
                    default: begin
                        r_acc <= r_acc;
                    end
                endcase
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == last_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        unique case (r_op)
            ALU_MUL:  o_res = r_acc;
            ALU_DIV:  o_res = r_opb;
            ALU_SQRT: o_res = r_opa;
            default:  o_res = r_acc;
        endcase
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
